@@ rtl/core/biq_pkg.sv @@
// Shared types and constants of the multichannel biquad filter.
package biq_pkg;

	localparam int CHAN_W   = 4;
	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 32;
	localparam int W_W      = 40;
	localparam int W_FRAC   = 8;
	localparam int LO_W     = 20;
	localparam int PART_W   = W_W - LO_W + 1;
	localparam int PROD_W   = COEF_W + PART_W;
	localparam int ACC_W    = 74;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	localparam logic [2:0] REG_A0 = 3'd0;
	localparam logic [2:0] REG_A1 = 3'd1;
	localparam logic [2:0] REG_A2 = 3'd2;
	localparam logic [2:0] REG_B1 = 3'd3;
	localparam logic [2:0] REG_B2 = 3'd4;

	localparam logic [2:0] FB_LAST = 3'd3;
	localparam logic [2:0] FF_LAST = 3'd5;

	localparam logic [1:0] Q_FULL = 2'd2;

	typedef struct packed {
		logic [CHAN_W-1:0]          chan_in;
		logic signed [SAMPLE_W-1:0] sample_in;
	} in_t;

	typedef struct packed {
		logic [CHAN_W-1:0]          chan_out;
		logic signed [SAMPLE_W-1:0] sample_out;
	} out_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
	} coef_t;

endpackage

@@ rtl/core/biq_ram.sv @@
// Generic single-port RAM with registered read.
module biq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ rtl/core/biq_regs.sv @@
// Coefficient registers behind the APB-style configuration port.
module biq_regs import biq_pkg::*; #(
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output coef_t              coef
);

	coef_t      coef_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign coef    = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a0 <= COEF_W'(1) << COEF_FRAC_BITS;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_A0: coef_q.a0 <= pwdata;
				REG_A1: coef_q.a1 <= pwdata;
				REG_A2: coef_q.a2 <= pwdata;
				REG_B1: coef_q.b1 <= pwdata;
				REG_B2: coef_q.b2 <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_A0: prdata = coef_q.a0;
			REG_A1: prdata = coef_q.a1;
			REG_A2: prdata = coef_q.a2;
			REG_B1: prdata = coef_q.b1;
			REG_B2: prdata = coef_q.b2;
			default: prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/biq_front.sv @@
// Front end: accepts requests, maps the channel to a state row, queues them.
module biq_front import biq_pkg::*; #(
	parameter int CHANNELS = 16,
	parameter int IDX_W    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  in_t              item,
	output logic             full,
	output logic             q_valid,
	input  logic             q_pop,
	output in_t              q_item,
	output logic [IDX_W-1:0] q_idx
);

	localparam int CODES = 1 << CHAN_W;

	logic [IDX_W-1:0] idx_tab [CODES];
	in_t              ent_item_q [2];
	logic [IDX_W-1:0] ent_idx_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	for (genvar g = 0; g < CODES; g++) begin : g_idx
		assign idx_tab[g] = IDX_W'(g % CHANNELS);
	end

	assign full    = (cnt_q == Q_FULL);
	assign q_valid = (cnt_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;
	assign q_item  = ent_item_q[rd_ptr_q];
	assign q_idx   = ent_idx_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_item_q[wr_ptr_q] <= item;
			ent_idx_q[wr_ptr_q]  <= idx_tab[item.chan_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("request queue count out of range");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!do_push && !do_pop) |=> $stable(cnt_q))
		else $error("request queue count changed without push or pop");

endmodule

@@ rtl/core/biq_back.sv @@
// Back end: shared multiply-accumulate engine, delay state and result register.
module biq_back import biq_pkg::*; #(
	parameter int CHANNELS       = 16,
	parameter int IDX_W          = 4,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic             clk,
	input  logic             arst_n,
	input  coef_t            coef,
	input  logic             q_valid,
	output logic             q_pop,
	input  in_t              q_item,
	input  logic [IDX_W-1:0] q_idx,
	output out_t             result,
	output logic             empty,
	input  logic             pop
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_LOAD     = 8'b0000_0010,
		ST_FB       = 8'b0000_0100,
		ST_DRAIN_FB = 8'b0000_1000,
		ST_W0       = 8'b0001_0000,
		ST_FF       = 8'b0010_0000,
		ST_DRAIN_FF = 8'b0100_0000,
		ST_OUT      = 8'b1000_0000
	} state_t;

	localparam logic [ACC_W-1:0] HALF_FB = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [ACC_W-1:0] HALF_Y  = ACC_W'(1) << (COEF_FRAC_BITS + W_FRAC - 1);

	state_t                   state_q;
	logic [2:0]               step_q;
	in_t                      item_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [W_W-1:0]    w0_q;
	logic signed [W_W-1:0]    w1_q;
	logic signed [W_W-1:0]    w2_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     hi_s1;
	logic                     mul_v_s1;
	logic                     out_valid_q;
	out_t                     result_q;
	logic [CHANNELS-1:0]      vld_q;
	logic                     rd_vld_q;

	logic                     issue;
	logic signed [COEF_W-1:0] mul_c;
	logic signed [W_W-1:0]    w_sel;
	logic signed [PART_W-1:0] mul_w;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  fb_sh;
	logic signed [ACC_W-1:0]  x_ext;
	logic signed [ACC_W-1:0]  w0_sum;
	logic signed [W_W-1:0]    w0_sat;
	logic signed [ACC_W-1:0]  y_sh;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic                     out_go;
	logic [IDX_W-1:0]         ram_addr;
	logic [2*W_W-1:0]         ram_rdata;

	assign issue  = (state_q == ST_FB) || (state_q == ST_FF);
	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign out_go = (state_q == ST_OUT) && (!out_valid_q || pop);
	assign empty  = !out_valid_q;
	assign result = result_q;

	always_comb begin
		mul_c = coef.b1;
		w_sel = w1_q;
		if (state_q == ST_FB) begin
			if (step_q[1]) begin
				mul_c = coef.b2;
				w_sel = w2_q;
			end
		end else begin
			case (step_q[2:1])
				2'd0: begin
					mul_c = coef.a0;
					w_sel = w0_q;
				end
				2'd1: begin
					mul_c = coef.a1;
					w_sel = w1_q;
				end
				default: begin
					mul_c = coef.a2;
					w_sel = w2_q;
				end
			endcase
		end
		mul_w = step_q[0] ? {w_sel[W_W-1], w_sel[W_W-1:LO_W]}
		                  : {1'b0, w_sel[LO_W-1:0]};
	end

	assign prod_ext = ACC_W'(prod_s1);
	assign addend   = hi_s1 ? (prod_ext <<< LO_W) : prod_ext;

	assign fb_sh  = acc_q >>> COEF_FRAC_BITS;
	assign x_ext  = ACC_W'(item_q.sample_in) <<< W_FRAC;
	assign w0_sum = fb_sh + x_ext;

	always_comb begin
		if ((&w0_sum[ACC_W-1:W_W-1]) || !(|w0_sum[ACC_W-1:W_W-1])) begin
			w0_sat = w0_sum[W_W-1:0];
		end else begin
			w0_sat = {w0_sum[ACC_W-1], {(W_W-1){!w0_sum[ACC_W-1]}}};
		end
	end

	assign y_sh = acc_q >>> (COEF_FRAC_BITS + W_FRAC);

	always_comb begin
		if ((&y_sh[ACC_W-1:SAMPLE_W-1]) || !(|y_sh[ACC_W-1:SAMPLE_W-1])) begin
			y_sat = y_sh[SAMPLE_W-1:0];
		end else begin
			y_sat = {y_sh[ACC_W-1], {(SAMPLE_W-1){!y_sh[ACC_W-1]}}};
		end
	end

	assign ram_addr = (state_q == ST_IDLE) ? q_idx : idx_q;

	biq_ram #(
		.WIDTH (2 * W_W),
		.DEPTH (CHANNELS),
		.AW    (IDX_W)
	) u_state_ram (
		.clk   (clk),
		.we    (out_go),
		.addr  (ram_addr),
		.wdata ({w0_q, w1_q}),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		prod_s1 <= mul_c * mul_w;
		hi_s1   <= step_q[0];
		if (q_pop) begin
			item_q   <= q_item;
			idx_q    <= q_idx;
			rd_vld_q <= vld_q[q_idx];
		end
		if (state_q == ST_LOAD) begin
			w1_q <= rd_vld_q ? ram_rdata[2*W_W-1:W_W] : '0;
			w2_q <= rd_vld_q ? ram_rdata[W_W-1:0] : '0;
			acc_q <= HALF_FB;
		end else if (state_q == ST_W0) begin
			w0_q  <= w0_sat;
			acc_q <= HALF_Y;
		end else if (mul_v_s1) begin
			acc_q <= acc_q + addend;
		end
		if (out_go) begin
			result_q.chan_out   <= item_q.chan_in;
			result_q.sample_out <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 3'd0;
			mul_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			mul_v_s1 <= issue;
			if (out_go) begin
				out_valid_q  <= 1'b1;
				vld_q[idx_q] <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q  <= 3'd0;
					state_q <= ST_FB;
				end
				ST_FB: begin
					if (step_q == FB_LAST) begin
						step_q  <= 3'd0;
						state_q <= ST_DRAIN_FB;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DRAIN_FB: state_q <= ST_W0;
				ST_W0:       state_q <= ST_FF;
				ST_FF: begin
					if (step_q == FF_LAST) begin
						step_q  <= 3'd0;
						state_q <= ST_DRAIN_FF;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_DRAIN_FF: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_LOAD))
		else $error("queue pop not followed by state load");

	a_mac_window: assert property (@(posedge clk) disable iff (!arst_n)
		mul_v_s1 |-> (state_q == ST_FB || state_q == ST_DRAIN_FB ||
		              state_q == ST_FF || state_q == ST_DRAIN_FF))
		else $error("product accumulated outside a multiply phase");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(result_q)))
		else $error("waiting result changed before pop");

	a_write_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_go |=> (out_valid_q && state_q == ST_IDLE))
		else $error("state write-back without result load");

endmodule

@@ rtl/core/multichannel_biquad_filter_top.sv @@
// Top level of the multichannel direct form II biquad filter.
// The filter engine works on one request at a time, taking the next only
// after write-back: one shared 32x21-bit signed multiplier forms the ten
// partial products of the five coefficient products (each 40-bit delay value
// split into two halves), with steps added for the state RAM read, the w0
// rounding and saturation step, and the write-back. A two-entry request queue
// takes new requests while the engine works, and a result register holds the
// finished result until popped. Delay state lives in a CHANNELS-deep RAM, one
// row per channel; a per-channel valid flag makes reset clear all channels at
// once, so no clearing pass is needed. Channels at or above CHANNELS use the
// row of their channel number modulo CHANNELS.
module multichannel_biquad_filter_top import biq_pkg::*; #(
	parameter int CHANNELS       = 16,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  in_t                item,
	output logic               full,
	output out_t               result,
	output logic               empty,
	input  logic               pop,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	coef_t            coef;
	logic             q_valid;
	logic             q_pop;
	in_t              q_item;
	logic [IDX_W-1:0] q_idx;

	biq_regs #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	biq_front #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.q_idx   (q_idx)
	);

	biq_back #(
		.CHANNELS       (CHANNELS),
		.IDX_W          (IDX_W),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.q_idx   (q_idx),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule
